[hdl/btr_pkg.sv]
// ----------------------------------------------------------------------------
// btr_pkg: shared types and constants for the block transfer receiver
// Frame layout, protocol bytes, event codes and receiver phase.
// ----------------------------------------------------------------------------
package btr_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int HDR_BYTES   = 3;
    localparam int POS_W       = $clog2(HDR_BYTES + BLOCK_BYTES + 1);

    localparam logic [POS_W-1:0] POS_START = POS_W'(0);
    localparam logic [POS_W-1:0] POS_NUM_HI = POS_W'(1);
    localparam logic [POS_W-1:0] POS_NUM_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_CSUM = POS_W'(HDR_BYTES + BLOCK_BYTES);

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] CAN_BYTE   = 8'h18;

    localparam logic [7:0] TIMEOUT_RESET = 8'd20;
    localparam logic [8:0] IDLE_MAX      = 9'd511;

    typedef enum logic [2:0] {
        EV_STAGE     = 3'd0,
        EV_COMMIT    = 3'd1,
        EV_DUPLICATE = 3'd2,
        EV_END       = 3'd3,
        EV_SEQ_ERR   = 3'd4,
        EV_BAD_START = 3'd5,
        EV_CSUM_ERR  = 3'd6,
        EV_TIMEOUT   = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        PH_RECEIVING = 2'd0,
        PH_HALTED    = 2'd1
    } phase_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

endpackage

[hdl/block_transfer_receiver.sv]
// ----------------------------------------------------------------------------
// block_transfer_receiver: receive side of a 256-byte block transfer
// Parses start byte, block number, data and checksum; reports verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per received uart
//   byte (req_type = 0, rx_byte) or per one-second tick (req_type = 1).
//   Output channel (out_valid / out_stall): at most one result per input
//   transaction - a data byte to stage, a frame verdict, or a timeout, with
//   the reply byte (ACK / CAN) to send back when reply_valid is set.
//   Configuration: cfg_wr_en / cfg_wr_data write timeout_seconds; write it
//   only while no transaction is in flight.
//   Timing: an accepted input is held in the input register, and its result
//   is then taken into the result register once that register can take a value.
//   Throughput: one transaction per cycle while the output is not stalled, set
//   by the single pass of frame logic between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more transaction; further input then stalls.
//   After bad start, checksum error, sequence error, end of transfer or a
//   timeout, every input is consumed without result until reset.
//   Reset (rst_n low) returns to receiving, expected block 1, timeout 20.
// ----------------------------------------------------------------------------
module block_transfer_receiver
    import btr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  stage_index,
    output logic [7:0]  stage_data,
    output logic [23:0] flash_offset,
    output logic [15:0] block_number,
    output logic        reply_valid,
    output logic [7:0]  reply_byte
);

    // input register
    logic       in_valid_reg;
    req_t       req_type_reg;
    logic [7:0] rx_byte_reg;

    // protocol state
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             start_ok_reg, start_ok_next;
    logic [15:0]      hdr_reg, hdr_next;
    logic [7:0]       sum_reg, sum_next;
    logic [15:0]      expected_reg, expected_next;
    logic [8:0]       idle_reg, idle_next;
    logic [7:0]       timeout_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    event_t      kind_reg, kind_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  data_reg, data_next;
    logic [23:0] offset_reg, offset_next;
    logic [15:0] num_reg, num_next;
    logic        rvalid_reg, rvalid_next;
    logic [7:0]  rbyte_reg, rbyte_next;

    logic        advance;
    logic        has_result;
    logic [8:0]  idle_plus;
    logic [23:0] commit_offset;

    // move the input register forward whenever the result register can take a value
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign idle_plus     = idle_reg + 9'd1;
    assign commit_offset = 24'(({8'd0, hdr_reg} - 24'd1) * 24'(BLOCK_BYTES));

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        start_ok_next = start_ok_reg;
        hdr_next      = hdr_reg;
        sum_next      = sum_reg;
        expected_next = expected_reg;
        idle_next     = idle_reg;
        if (advance && phase_reg == PH_RECEIVING)
        begin
            if (req_type_reg == REQ_TICK)
            begin
                if (idle_reg != IDLE_MAX)
                    idle_next = idle_plus;
                if (idle_next > {1'b0, timeout_reg})
                    phase_next = PH_HALTED;
            end
            else
            begin
                idle_next = '0;
                if (pos_reg == POS_START)
                begin
                    start_ok_next = (rx_byte_reg == START_BYTE);
                    hdr_next      = '0;
                    sum_next      = '0;
                    pos_next      = POS_NUM_HI;
                end
                else if (pos_reg == POS_NUM_HI)
                begin
                    hdr_next = {rx_byte_reg, 8'd0};
                    pos_next = POS_NUM_LO;
                end
                else if (pos_reg == POS_NUM_LO)
                begin
                    hdr_next = {hdr_reg[15:8], rx_byte_reg};
                    pos_next = POS_DATA;
                end
                else if (pos_reg < POS_CSUM)
                begin
                    sum_next = sum_reg + rx_byte_reg;
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = POS_START;
                    if (!start_ok_reg || sum_reg != rx_byte_reg || hdr_reg == 16'd0)
                        phase_next = PH_HALTED;
                    else if (hdr_reg == expected_reg)
                        expected_next = expected_reg + 16'd1;
                    else if (hdr_reg != expected_reg - 16'd1)
                        phase_next = PH_HALTED;
                end
            end
        end
    end

    // result
    always_comb
    begin
        has_result  = 1'b0;
        kind_next   = EV_STAGE;
        index_next  = '0;
        data_next   = '0;
        offset_next = '0;
        num_next    = hdr_reg;
        rvalid_next = 1'b0;
        rbyte_next  = '0;
        if (phase_reg == PH_RECEIVING)
        begin
            if (req_type_reg == REQ_TICK)
            begin
                num_next = '0;
                if (idle_next > {1'b0, timeout_reg})
                begin
                    has_result = 1'b1;
                    kind_next  = EV_TIMEOUT;
                end
            end
            else if (pos_reg >= POS_DATA && pos_reg < POS_CSUM)
            begin
                has_result = 1'b1;
                kind_next  = EV_STAGE;
                index_next = 8'(pos_reg - POS_DATA);
                data_next  = rx_byte_reg;
            end
            else if (pos_reg == POS_CSUM)
            begin
                has_result = 1'b1;
                if (!start_ok_reg)
                    kind_next = EV_BAD_START;
                else if (sum_reg != rx_byte_reg)
                    kind_next = EV_CSUM_ERR;
                else if (hdr_reg == 16'd0)
                begin
                    kind_next   = EV_END;
                    num_next    = '0;
                    rvalid_next = 1'b1;
                    rbyte_next  = ACK_BYTE;
                end
                else if (hdr_reg == expected_reg)
                begin
                    kind_next   = EV_COMMIT;
                    offset_next = commit_offset;
                    rvalid_next = 1'b1;
                    rbyte_next  = ACK_BYTE;
                end
                else if (hdr_reg == expected_reg - 16'd1)
                begin
                    kind_next   = EV_DUPLICATE;
                    rvalid_next = 1'b1;
                    rbyte_next  = ACK_BYTE;
                end
                else
                begin
                    kind_next   = EV_SEQ_ERR;
                    rvalid_next = 1'b1;
                    rbyte_next  = CAN_BYTE;
                end
            end
        end
    end

    always_comb
    begin
        if (advance && has_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_RECEIVING;
            pos_reg       <= POS_START;
            start_ok_reg  <= 1'b0;
            hdr_reg       <= '0;
            sum_reg       <= '0;
            expected_reg  <= 16'd1;
            idle_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            start_ok_reg  <= start_ok_next;
            hdr_reg       <= hdr_next;
            sum_reg       <= sum_next;
            expected_reg  <= expected_next;
            idle_reg      <= idle_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_type_reg <= req_t'(req_type);
            rx_byte_reg  <= rx_byte;
        end
        if (advance && has_result)
        begin
            kind_reg   <= kind_next;
            index_reg  <= index_next;
            data_reg   <= data_next;
            offset_reg <= offset_next;
            num_reg    <= num_next;
            rvalid_reg <= rvalid_next;
            rbyte_reg  <= rbyte_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign stage_index  = index_reg;
    assign stage_data   = data_reg;
    assign flash_offset = offset_reg;
    assign block_number = num_reg;
    assign reply_valid  = rvalid_reg;
    assign reply_byte   = rbyte_reg;

    // once halted, stay halted until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALTED |=> phase_reg == PH_HALTED)
        else $error("receiver left halted phase");

    // expected block number moves only on a commit verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(expected_reg) |-> $past(advance && has_result && kind_next == EV_COMMIT))
        else $error("expected block number changed without commit");

    // frame position never passes the checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CSUM)
        else $error("frame position out of range");

    // a held result must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(kind_reg) && $stable(num_reg))
        else $error("stalled result changed");

    // reply flag follows the verdict kind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && reply_valid |->
            (kind_reg == EV_COMMIT || kind_reg == EV_DUPLICATE ||
             kind_reg == EV_END || kind_reg == EV_SEQ_ERR))
        else $error("reply on a verdict that takes none");

endmodule
